// ===== hw/rtl/security_event_monitor_core_assert.svh =====
// Assertion macros used by the security event monitor RTL.
`ifndef SECURITY_EVENT_MONITOR_CORE_ASSERT_SVH
`define SECURITY_EVENT_MONITOR_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SEM_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SEM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

  // Event codes
  localparam logic [1:0] OP_TAMPER   = 2'd0;
  localparam logic [1:0] OP_BUTTON   = 2'd1;
  localparam logic [1:0] OP_VIBRATE  = 2'd2;
  localparam logic [1:0] OP_CHECKSUM = 2'd3;

  // Security levels
  localparam logic [1:0] LEVEL_NORMAL     = 2'd0;
  localparam logic [1:0] LEVEL_SUSPICIOUS = 2'd1;
  localparam logic [1:0] LEVEL_DEGRADED   = 2'd2;
  localparam logic [1:0] LEVEL_ALERT      = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_DETECT_SCORE      = 3'd0;
  localparam logic [2:0] REG_TAMPER_STEP       = 3'd1;
  localparam logic [2:0] REG_RAW_TAMPER_LEVEL  = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE_TIME     = 3'd3;
  localparam logic [2:0] REG_VIBRATION_LIMIT   = 3'd4;
  localparam logic [2:0] REG_EXPECTED_CHECKSUM = 3'd5;

  // Register reset values
  localparam logic [6:0]  RST_DETECT_SCORE      = 7'd80;
  localparam logic [6:0]  RST_TAMPER_STEP       = 7'd5;
  localparam logic [7:0]  RST_RAW_TAMPER_LEVEL  = 8'd245;
  localparam logic [15:0] RST_DEBOUNCE_TIME     = 16'd200;
  localparam logic [30:0] RST_VIBRATION_LIMIT   = 31'd6400;
  localparam logic [31:0] RST_EXPECTED_CHECKSUM = 32'h2144_DF1C;

  localparam logic [6:0] SCORE_MAX = 7'd100;

  typedef struct packed {
    logic [6:0]  detect_score;
    logic [6:0]  tamper_step;
    logic [7:0]  raw_tamper_level;
    logic [15:0] debounce_time;
    logic [30:0] vibration_limit;
    logic [31:0] expected_checksum;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  tamper_sample;
    logic [31:0] edge_time;
    logic signed [31:0] vibration_level;
    logic [31:0] packet_checksum;
  } item_t;

  typedef struct packed {
    logic [1:0]  security_level;
    logic        tamper_flag;
    logic [6:0]  score;
    logic        latch_set;
    logic        vibration_flag;
    logic        integrity_flag;
    logic [31:0] failure_total;
    logic        edge_accepted;
  } res_t;

endpackage

// ===== hw/rtl/sem_cfg_regs.sv =====
`timescale 1ns / 1ps

module sem_cfg_regs
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  // Decode writes, mask each value to its register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_score      <= RST_DETECT_SCORE;
      cfg.tamper_step       <= RST_TAMPER_STEP;
      cfg.raw_tamper_level  <= RST_RAW_TAMPER_LEVEL;
      cfg.debounce_time     <= RST_DEBOUNCE_TIME;
      cfg.vibration_limit   <= RST_VIBRATION_LIMIT;
      cfg.expected_checksum <= RST_EXPECTED_CHECKSUM;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DETECT_SCORE:      cfg.detect_score      <= cfg_data[6:0];
        REG_TAMPER_STEP:       cfg.tamper_step       <= cfg_data[6:0];
        REG_RAW_TAMPER_LEVEL:  cfg.raw_tamper_level  <= cfg_data[7:0];
        REG_DEBOUNCE_TIME:     cfg.debounce_time     <= cfg_data[15:0];
        REG_VIBRATION_LIMIT:   cfg.vibration_limit   <= cfg_data[30:0];
        REG_EXPECTED_CHECKSUM: cfg.expected_checksum <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sem_monitor_state.sv =====
`timescale 1ns / 1ps

module sem_monitor_state
  import sem_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res_next
);

  `include "security_event_monitor_core_assert.svh"

  logic                   latch;
  logic [6:0]             score;
  logic                   detected;
  logic                   vibration;
  logic                   fault;
  logic [COUNT_WIDTH-1:0] failures;
  logic [31:0]            last_edge;

  logic                   latch_next;
  logic [6:0]             score_next;
  logic                   detected_next;
  logic                   vibration_next;
  logic                   fault_next;
  logic [COUNT_WIDTH-1:0] failures_next;
  logic [31:0]            last_edge_next;
  logic                   accepted;

  logic [7:0]         score_sum;
  logic [6:0]         score_tmp;
  logic [31:0]        edge_delta;
  logic signed [32:0] vib_wide;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;
  logic               mismatch;
  logic [1:0]         level;

  // Arithmetic for the event paths
  assign score_sum  = {1'b0, score} + {1'b0, cfg.tamper_step};
  assign edge_delta = item.edge_time - last_edge;
  assign vib_wide   = {item.vibration_level[31], item.vibration_level};
  assign lim_pos    = {2'b00, cfg.vibration_limit};
  assign lim_neg    = -lim_pos;
  assign mismatch   = item.packet_checksum != cfg.expected_checksum;

  // Work out the state after the current event
  always_comb begin
    latch_next     = latch;
    score_next     = score;
    detected_next  = detected;
    vibration_next = vibration;
    fault_next     = fault;
    failures_next  = failures;
    last_edge_next = last_edge;
    accepted       = 1'b0;
    score_tmp      = score;
    case (item.op)
      OP_TAMPER: begin
        if (item.tamper_sample > cfg.raw_tamper_level) begin
          score_tmp = (score_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : score_sum[6:0];
        end else if (score != 7'd0 && !latch) begin
          score_tmp = score - 7'd1;
        end
        if (latch) begin
          score_tmp = SCORE_MAX;
        end
        score_next    = score_tmp;
        detected_next = latch || (score_tmp >= cfg.detect_score);
      end
      OP_BUTTON: begin
        if (edge_delta >= {16'd0, cfg.debounce_time}) begin
          accepted       = 1'b1;
          last_edge_next = item.edge_time;
          latch_next     = !latch;
          score_next     = latch ? 7'd0 : SCORE_MAX;
          detected_next  = !latch;
        end
      end
      OP_VIBRATE: begin
        vibration_next = (vib_wide > lim_pos) || (vib_wide < lim_neg);
      end
      OP_CHECKSUM: begin
        fault_next = mismatch;
        if (mismatch && failures != '1) begin
          failures_next = failures + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Rank the level: alert, degraded, suspicious, normal
  always_comb begin
    if (latch_next || detected_next) begin
      level = LEVEL_ALERT;
    end else if (fault_next) begin
      level = LEVEL_DEGRADED;
    end else if (vibration_next) begin
      level = LEVEL_SUSPICIOUS;
    end else begin
      level = LEVEL_NORMAL;
    end
  end

  // Snapshot for the result register
  always_comb begin
    res_next.security_level = level;
    res_next.tamper_flag    = detected_next;
    res_next.score          = score_next;
    res_next.latch_set      = latch_next;
    res_next.vibration_flag = vibration_next;
    res_next.integrity_flag = fault_next;
    res_next.failure_total  = 32'(failures_next);
    res_next.edge_accepted  = accepted;
  end

  // Commit state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      latch     <= 1'b0;
      score     <= 7'd0;
      detected  <= 1'b0;
      vibration <= 1'b0;
      fault     <= 1'b0;
      failures  <= '0;
      last_edge <= 32'd0;
    end else if (advance) begin
      latch     <= latch_next;
      score     <= score_next;
      detected  <= detected_next;
      vibration <= vibration_next;
      fault     <= fault_next;
      failures  <= failures_next;
      last_edge <= last_edge_next;
    end
  end

  `SEM_ASSERT_SAME(a_score_range, 1'b1, score <= SCORE_MAX)
  `SEM_ASSERT_SAME(a_latch_forces_alert, latch, detected && score == SCORE_MAX)
  `SEM_ASSERT_NEXT(a_edge_toggles_latch, advance && accepted, latch != $past(latch))

endmodule

// ===== hw/rtl/security_event_monitor_core.sv =====
`timescale 1ns / 1ps

// Security event monitor core.
// Input channel (in_valid/in_stall): one event request per accepted cycle, selected
// by op: tamper sample, button edge, vibration value or packet checksum.
// Output channel (out_valid/out_stall): one result per event, a snapshot of the
// monitor state after that event, in event order.
// Config port: cfg_write with cfg_index/cfg_data writes one register per cycle;
// write only while no request is in flight. Unknown indexes are ignored.
// Path: an accepted request waits in the input register while the update logic runs,
// then loads the result register once that register is free or being drained.
// Throughput: one request per cycle while in_stall is low; the state update is a
// single pass of compares, subtracts and saturating adds between the input and
// result registers.
// Reset (rst, synchronous): clears state, flags, counters and both pipeline valids
// and restores register defaults.
// Stall: a held result keeps out_valid and its fields; the input register still
// takes a request while the result register is free or being drained, and in_stall
// rises only when both stages are full and out_stall is high.
module security_event_monitor_core
  import sem_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  tamper_sample,
  input  logic [31:0] edge_time,
  input  logic signed [31:0] vibration_level,
  input  logic [31:0] packet_checksum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  security_level,
  output logic        tamper_flag,
  output logic [6:0]  score,
  output logic        latch_set,
  output logic        vibration_flag,
  output logic        integrity_flag,
  output logic [31:0] failure_total,
  output logic        edge_accepted
);

  cfg_t  cfg;
  item_t item;
  res_t  res_next;
  res_t  res;
  logic  item_valid;
  logic  advance;
  logic  in_take;

  sem_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sem_monitor_state #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Move the held request on when the result register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.op              <= op;
      item.tamper_sample   <= tamper_sample;
      item.edge_time       <= edge_time;
      item.vibration_level <= vibration_level;
      item.packet_checksum <= packet_checksum;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign security_level = res.security_level;
  assign tamper_flag    = res.tamper_flag;
  assign score          = res.score;
  assign latch_set      = res.latch_set;
  assign vibration_flag = res.vibration_flag;
  assign integrity_flag = res.integrity_flag;
  assign failure_total  = res.failure_total;
  assign edge_accepted  = res.edge_accepted;

endmodule
